FILE: hw/rtl/decimal_digit_blanking_writer_unit_defines.svh
// ----------------------------------------------------------------------------
// Decimal digit blanking writer - assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_DIGIT_BLANKING_WRITER_UNIT_DEFINES_SVH
`define DECIMAL_DIGIT_BLANKING_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define DDBW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define DDBW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ddbw_pkg.sv
// ----------------------------------------------------------------------------
// Decimal digit blanking writer - package
// Field widths, codes, state type and defaults shared by the interfaces and
// the top level.
// ----------------------------------------------------------------------------
package ddbw_pkg;

   // Payload field widths
   localparam int TILE_W   = 11;
   localparam int NUMBER_W = 20;
   localparam int COUNT_W  = 3;
   localparam int MODE_W   = 2;
   localparam int ADDR_W   = 16;
   localparam int DIGIT_W  = 4;
   localparam int ACT_W    = 2;

   // Parameter defaults
   localparam int DEF_MAX_DIGITS = 6;
   localparam int DEF_TILE_BYTES = 32;

   // Each glyph cell is 64 bytes
   localparam logic [ADDR_W-1:0] CELL_BYTES = 16'd64;

   // Divide by ten: q = (v * ceil(2^23 / 10)) >> 23, exact for v < 2^22
   localparam logic [NUMBER_W-1:0] DIV10_MAGIC = 20'd838861;
   localparam int                  DIV10_SHIFT = 23;

   // Top digit when the value does not fit
   localparam logic [DIGIT_W-1:0] DIGIT_SAT = 4'd15;

   // Blanking modes (mode three behaves as skip)
   localparam logic [MODE_W-1:0] MODE_SKIP  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

   // Cell actions
   localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACT_W-1:0] ACT_KEEP  = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } ddbw_state_type;

endpackage

FILE: hw/rtl/ddbw_req_if.sv
// ----------------------------------------------------------------------------
// Decimal digit blanking writer - request channel
// Valid/ready channel carrying one value to display.
// ----------------------------------------------------------------------------
interface ddbw_req_if import ddbw_pkg::*;;
   logic                valid;
   logic                ready;
   logic [TILE_W-1:0]   base_tile;
   logic [NUMBER_W-1:0] number;
   logic [COUNT_W-1:0]  digit_count;
   logic [MODE_W-1:0]   blank_mode;

   modport source (
      output valid, base_tile, number, digit_count, blank_mode,
      input  ready
   );

   modport sink (
      input  valid, base_tile, number, digit_count, blank_mode,
      output ready
   );
endinterface

FILE: hw/rtl/ddbw_rsp_if.sv
// ----------------------------------------------------------------------------
// Decimal digit blanking writer - response channel
// Valid/ready channel carrying one digit cell operation.
// ----------------------------------------------------------------------------
interface ddbw_rsp_if import ddbw_pkg::*;;
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  glyph_addr;
   logic [DIGIT_W-1:0] digit_value;
   logic [ACT_W-1:0]   action;
   logic               overflow;
   logic               last;

   modport source (
      output valid, glyph_addr, digit_value, action, overflow, last,
      input  ready
   );

   modport sink (
      input  valid, glyph_addr, digit_value, action, overflow, last,
      output ready
   );
endinterface

FILE: hw/rtl/decimal_digit_blanking_writer_unit.sv
// ----------------------------------------------------------------------------
// Decimal digit blanking writer - top level
// Turns a binary value into per-digit glyph cell operations, most
// significant digit first, with leading zero blanking.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch takes one request: base tile, value, digit count (0 acts as 1,
//   above MAX_DIGITS clamps) and blanking mode. rsp_ch returns one response
//   per digit, top digit first, with last set on the final one.
//   Timing: a request is taken only while the unit is idle. One shared
//   divide-by-ten unit (reciprocal multiply plus subtract) peels one digit a
//   cycle into a small digit file, lowest first. The digits are then read
//   back top first, one response a cycle while rsp_ch.ready is high.
//   Stalls: while rsp_ch.ready is low the current response holds steady and
//   the sequencer waits; req_ch.ready stays low until the last response of
//   the request has been taken.
//   Reset: synchronous, active high; returns the sequencer to idle and
//   drops any request in flight. No other state survives a request.
// ----------------------------------------------------------------------------
`include "decimal_digit_blanking_writer_unit_defines.svh"

module decimal_digit_blanking_writer_unit import ddbw_pkg::*; #(
   parameter int MAX_DIGITS = DEF_MAX_DIGITS,
   parameter int TILE_BYTES = DEF_TILE_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   ddbw_req_if.sink   req_ch,
   ddbw_rsp_if.source rsp_ch
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   // Sequencer and working registers
   ddbw_state_type      state_ff, state_in;
   logic [NUMBER_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic                seen_ff, seen_in;
   logic                ovf_ff, ovf_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;

   // Digit file, lowest digit at index zero
   logic [DIGIT_W-1:0]  digits_ff [MAX_DIGITS];
   logic                digit_we;
   logic [DIGIT_W-1:0]  digit_wdata;

   // Shared divide-by-ten unit
   logic [2*NUMBER_W-1:0] div_prod;
   logic [NUMBER_W-1:0]   div_quot;
   logic [NUMBER_W-1:0]   div_rem;

   // Response datapath
   logic [COUNT_W-1:0]  count_raw;
   logic [CNT_W-1:0]    top_idx;
   logic                at_top;
   logic [DIGIT_W-1:0]  out_digit;
   logic                seen_now;
   logic [ACT_W-1:0]    out_act;

   // Quotient and remainder of the working value
   always_comb begin
      div_prod = value_ff * DIV10_MAGIC;
      div_quot = NUMBER_W'(div_prod >> DIV10_SHIFT);
      div_rem  = value_ff - ((div_quot << 3) + (div_quot << 1));
   end

   // Current response fields
   always_comb begin
      top_idx   = count_ff - CNT_W'(1);
      at_top    = (step_ff == top_idx);
      out_digit = (at_top && ovf_ff) ? DIGIT_SAT : digits_ff[step_ff[IDX_W-1:0]];
      seen_now  = seen_ff || (out_digit != '0);
      if (seen_now) begin
         out_act = ACT_WRITE;
      end else if (mode_ff == MODE_CLEAR) begin
         out_act = ACT_CLEAR;
      end else begin
         out_act = ACT_KEEP;
      end
   end

   assign count_raw = (req_ch.digit_count == '0) ? COUNT_W'(1) : req_ch.digit_count;

   // Next state and register updates
   always_comb begin
      state_in    = state_ff;
      value_in    = value_ff;
      step_in     = step_ff;
      count_in    = count_ff;
      mode_in     = mode_ff;
      seen_in     = seen_ff;
      ovf_in      = ovf_ff;
      addr_in     = addr_ff;
      digit_we    = 1'b0;
      digit_wdata = div_rem[DIGIT_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_DIVIDE;
               value_in = req_ch.number;
               step_in  = '0;
               if (int'(count_raw) > MAX_DIGITS) begin
                  count_in = CNT_W'(MAX_DIGITS);
               end else begin
                  count_in = CNT_W'(count_raw);
               end
               mode_in  = req_ch.blank_mode;
               seen_in  = (req_ch.blank_mode == MODE_WRITE);
               ovf_in   = 1'b0;
               addr_in  = ADDR_W'(32'(req_ch.base_tile) * TILE_BYTES);
            end
         end
         ST_DIVIDE: begin
            // One digit per cycle, lowest first
            digit_we = 1'b1;
            value_in = div_quot;
            if (step_ff == top_idx) begin
               // Anything left above the top place is overflow
               ovf_in   = (div_quot != '0);
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_ch.ready) begin
               seen_in = seen_now;
               addr_in = addr_ff + CELL_BYTES;
               if (step_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      step_ff  <= step_in;
      count_ff <= count_in;
      mode_ff  <= mode_in;
      seen_ff  <= seen_in;
      ovf_ff   <= ovf_in;
      addr_ff  <= addr_in;
      if (digit_we) begin
         digits_ff[step_ff[IDX_W-1:0]] <= digit_wdata;
      end
   end

   // Channel outputs
   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = (state_ff == ST_EMIT);
   assign rsp_ch.glyph_addr  = addr_ff;
   assign rsp_ch.digit_value = out_digit;
   assign rsp_ch.action      = out_act;
   assign rsp_ch.overflow    = ovf_ff;
   assign rsp_ch.last        = (step_ff == '0);

   // Checks
   `DDBW_ASSERT_IMP(a_no_overlap, clock, reset, req_ch.ready, !rsp_ch.valid,
      "request taken while responses pending")
   `DDBW_ASSERT_NEXT(a_last_frees, clock, reset,
      rsp_ch.valid && rsp_ch.ready && rsp_ch.last, req_ch.ready,
      "unit not idle after last response")
   `DDBW_ASSERT_NEXT(a_ovf_steady, clock, reset,
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last,
      rsp_ch.valid && (rsp_ch.overflow == $past(rsp_ch.overflow)),
      "overflow flag changed within one value")
   `DDBW_ASSERT_IMP(a_blank_zero, clock, reset,
      rsp_ch.valid && (rsp_ch.action != ACT_WRITE), rsp_ch.digit_value == '0,
      "blanked cell carries a nonzero digit")

endmodule
